FILE: src/vpm_pkg.sv
// ============================================================================
// vpm_pkg
// Shared constants, register codes and types of the vertical pattern matcher.
// ============================================================================
package vpm_pkg;

  localparam int GRID_SIZE   = 16;
  localparam int MAX_PATTERN = 8;
  localparam int DEPTH       = MAX_PATTERN - 1;

  localparam int CHAR_W  = 8;
  localparam int LINE_W  = CHAR_W * DEPTH;
  localparam int POS_W   = $clog2(GRID_SIZE);
  localparam int CNT_W   = $clog2(GRID_SIZE + 1);
  localparam int LEN_W   = 4;
  localparam int WIDTH_W = 5;
  localparam int TOTAL_W = 12;
  localparam int PAT_W   = CHAR_W * MAX_PATTERN;
  localparam int PIDX_W  = $clog2(MAX_PATTERN);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(2048);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_LENGTH  = 2'd1;
  localparam logic [1:0] REG_WIDTH   = 2'd2;

  typedef struct packed {
    logic [PAT_W-1:0]   pattern;
    logic [LEN_W-1:0]   length;
    logic [WIDTH_W-1:0] row_width;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] pat_byte(input logic [PAT_W-1:0]  pat,
                                                 input logic [PIDX_W-1:0] k);
    pat_byte = pat[k*CHAR_W +: CHAR_W];
  endfunction

endpackage

FILE: src/vertical_pattern_match_grid.sv
// ============================================================================
// vertical_pattern_match_grid
// The accepting edge loads the compare stage, and the output register is loaded
// as that stage advances. Throughput: one transaction per cycle, set by
// the read-compare-write of one line-buffer row per cycle with write forwarding.
// Input stalls only while a result waits in a stalled output register.
// Reset clears position, total and valid flags; the line buffer is not cleared.
// ============================================================================
module vertical_pattern_match_grid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vpm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vpm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vpm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [vpm_pkg::CHAR_W-1:0]       grid_char_i,
  input  logic                             end_of_grid_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             matched_o,
  output logic [vpm_pkg::POS_W-1:0]        match_row_o,
  output logic [vpm_pkg::POS_W-1:0]        match_col_o,
  output logic [vpm_pkg::TOTAL_W-1:0]      total_count_o,
  output logic                             grid_done_o
);

  vpm_pkg::cfg_t cfg;

  logic [vpm_pkg::LEN_W-1:0]   len_c;
  logic [vpm_pkg::WIDTH_W-1:0] width_c;

  logic [vpm_pkg::CNT_W-1:0]   col_q;
  logic [vpm_pkg::POS_W-1:0]   row_q;
  logic [vpm_pkg::POS_W-1:0]   col_cur, row_cur;
  logic                        wrap;
  logic                        accept;

  logic                        s1_valid_q;
  logic [vpm_pkg::CHAR_W-1:0]  s1_char_q;
  logic                        s1_last_q;
  logic [vpm_pkg::POS_W-1:0]   s1_col_q, s1_row_q;
  logic                        byp_q;
  logic [vpm_pkg::LINE_W-1:0]  byp_data_q;
  logic                        s1_adv, produce, slot_free;

  logic [vpm_pkg::LINE_W-1:0]  ram_rdata, column, column_new;
  logic                        hit;
  logic [vpm_pkg::POS_W-1:0]   start_row;
  logic [vpm_pkg::TOTAL_W-1:0] total_q, total_new;

  logic                        out_valid_q, matched_q, done_q;
  logic [vpm_pkg::POS_W-1:0]   out_row_q, out_col_q;
  logic [vpm_pkg::TOTAL_W-1:0] out_total_q;

  vpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign len_c   = (cfg.length == '0) ? vpm_pkg::LEN_W'(1) :
                   (cfg.length > vpm_pkg::LEN_W'(vpm_pkg::MAX_PATTERN)) ?
                   vpm_pkg::LEN_W'(vpm_pkg::MAX_PATTERN) : cfg.length;
  assign width_c = (cfg.row_width == '0) ? vpm_pkg::WIDTH_W'(1) :
                   (cfg.row_width > vpm_pkg::WIDTH_W'(vpm_pkg::GRID_SIZE)) ?
                   vpm_pkg::WIDTH_W'(vpm_pkg::GRID_SIZE) : cfg.row_width;

  assign wrap    = vpm_pkg::WIDTH_W'(col_q) >= width_c;
  assign col_cur = wrap ? '0 : col_q[vpm_pkg::POS_W-1:0];
  assign row_cur = !wrap ? row_q :
                   (row_q == vpm_pkg::POS_W'(vpm_pkg::GRID_SIZE - 1)) ? '0 :
                   row_q + vpm_pkg::POS_W'(1);

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign produce    = hit || s1_last_q;
  assign s1_adv     = s1_valid_q && (!produce || slot_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  vpm_ram #(
    .WIDTH (vpm_pkg::LINE_W),
    .DEPTH (vpm_pkg::GRID_SIZE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (column_new),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  assign column = byp_q ? byp_data_q : ram_rdata;

  vpm_match u_match (
    .column_i    (column),
    .char_i      (s1_char_q),
    .pattern_i   (cfg.pattern),
    .len_i       (len_c),
    .row_i       (s1_row_q),
    .total_i     (total_q),
    .hit_o       (hit),
    .start_row_o (start_row),
    .total_o     (total_new),
    .column_o    (column_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (end_of_grid_i) begin
          col_q <= '0;
          row_q <= '0;
        end else begin
          col_q <= {1'b0, col_cur} + vpm_pkg::CNT_W'(1);
          row_q <= row_cur;
        end
        s1_valid_q <= 1'b1;
        byp_q      <= s1_adv && (s1_col_q == col_cur);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        total_q <= s1_last_q ? '0 : total_new;
      end
      if (s1_adv && produce) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_char_q  <= grid_char_i;
      s1_last_q  <= end_of_grid_i;
      s1_col_q   <= col_cur;
      s1_row_q   <= row_cur;
      byp_data_q <= column_new;
    end
    if (s1_adv && produce) begin
      matched_q   <= hit;
      out_row_q   <= hit ? start_row : '0;
      out_col_q   <= hit ? s1_col_q : '0;
      out_total_q <= total_new;
      done_q      <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = matched_q;
  assign match_row_o   = out_row_q;
  assign match_col_o   = out_col_q;
  assign total_count_o = out_total_q;
  assign grid_done_o   = done_q;

`ifndef SYNTHESIS
  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("Input stalled with no transaction in the compare stage.");

  a_end_resets_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_grid_i) |=> (col_q == '0 && row_q == '0))
    else $error("Grid position not cleared after the final character.");

  a_nomatch_is_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> grid_done_o)
    else $error("Result without a match that does not close the grid.");

  a_total_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (total_count_o <= vpm_pkg::TOTAL_MAX))
    else $error("Running total exceeded its saturation limit.");
`endif

endmodule

FILE: src/vpm_ram.sv
// ============================================================================
// vpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module vpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/vpm_cfg.sv
// ============================================================================
// vpm_cfg
// APB-style register file holding the pattern, its length and the row width.
// ============================================================================
module vpm_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vpm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vpm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vpm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output vpm_pkg::cfg_t                    cfg_o
);

  vpm_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[vpm_pkg::APB_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern   <= '0;
      cfg_q.length    <= vpm_pkg::LEN_W'(3);
      cfg_q.row_width <= vpm_pkg::WIDTH_W'(10);
    end else if (wr_en) begin
      case (reg_idx)
        vpm_pkg::REG_PATTERN: cfg_q.pattern   <= pwdata[vpm_pkg::PAT_W-1:0];
        vpm_pkg::REG_LENGTH:  cfg_q.length    <= pwdata[vpm_pkg::LEN_W-1:0];
        vpm_pkg::REG_WIDTH:   cfg_q.row_width <= pwdata[vpm_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vpm_pkg::REG_PATTERN: prdata = vpm_pkg::APB_DATA_W'(cfg_q.pattern);
      vpm_pkg::REG_LENGTH:  prdata = vpm_pkg::APB_DATA_W'(cfg_q.length);
      vpm_pkg::REG_WIDTH:   prdata = vpm_pkg::APB_DATA_W'(cfg_q.row_width);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/vpm_match.sv
// ============================================================================
// vpm_match
// Column compare against the pattern, total update and line-buffer shift.
// ============================================================================
module vpm_match (
  input  logic [vpm_pkg::LINE_W-1:0]  column_i,
  input  logic [vpm_pkg::CHAR_W-1:0]  char_i,
  input  logic [vpm_pkg::PAT_W-1:0]   pattern_i,
  input  logic [vpm_pkg::LEN_W-1:0]   len_i,
  input  logic [vpm_pkg::POS_W-1:0]   row_i,
  input  logic [vpm_pkg::TOTAL_W-1:0] total_i,
  output logic                        hit_o,
  output logic [vpm_pkg::POS_W-1:0]   start_row_o,
  output logic [vpm_pkg::TOTAL_W-1:0] total_o,
  output logic [vpm_pkg::LINE_W-1:0]  column_o
);

  logic                        enough_rows;
  logic                        hit;
  logic [vpm_pkg::LEN_W-1:0]   pidx;
  logic [vpm_pkg::TOTAL_W-1:0] sum;

  assign enough_rows = ({1'b0, row_i} + 5'd1) >= {1'b0, len_i};

  always_comb begin
    pidx = vpm_pkg::LEN_W'(len_i - 4'd1);
    hit  = enough_rows &&
           (vpm_pkg::pat_byte(pattern_i, pidx[vpm_pkg::PIDX_W-1:0]) == char_i);
    for (int d = 0; d < vpm_pkg::DEPTH; d++) begin
      pidx = vpm_pkg::LEN_W'(len_i - vpm_pkg::LEN_W'(d) - 4'd2);
      if ((vpm_pkg::LEN_W'(d) + 4'd2) <= len_i) begin
        if (column_i[d*vpm_pkg::CHAR_W +: vpm_pkg::CHAR_W] !=
            vpm_pkg::pat_byte(pattern_i, pidx[vpm_pkg::PIDX_W-1:0])) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign sum         = total_i + vpm_pkg::TOTAL_W'(len_i);
  assign hit_o       = hit;
  assign start_row_o = vpm_pkg::POS_W'(row_i + vpm_pkg::POS_W'(1) - len_i);
  assign total_o     = !hit ? total_i :
                       (sum > vpm_pkg::TOTAL_MAX) ? vpm_pkg::TOTAL_MAX : sum;
  assign column_o    = {column_i[vpm_pkg::LINE_W-vpm_pkg::CHAR_W-1:0], char_i};

endmodule

FILE: tb/tb_vertical_pattern_match_grid.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_vertical_pattern_match_grid
// Self-checking testbench for the vertical pattern matcher. A short table of
// directed transactions is followed by random grids whose columns carry the
// configured pattern with random corruption, plus noise and cut-short grids.
// Every accepted character steps a local model of the column buffers, and
// each result from the block is compared with the oldest expected one.
// ============================================================================
module tb_vertical_pattern_match_grid;
  import vpm_pkg::*;

  localparam logic [1:0] REG_UNUSED     = 2'd3;
  localparam int         ITEM_TARGET    = 1350;
  localparam int         CALM_AFTER     = 1150;
  localparam int         SATURATE_AFTER = 250;
  localparam int         SATURATE_ITEMS = 480;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         DRAIN_CYCLES   = 10;
  localparam int         WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic               matched;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [TOTAL_W-1:0] total;
    logic               done;
  } match_rec_t;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        reg_idx;
    logic [63:0]       value;
    logic [CHAR_W-1:0] ch;
    logic              eog;
    logic              known;
    logic              known_has;
    match_rec_t        res;
  } grid_step_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [CHAR_W-1:0]     grid_char_i   = '0;
  logic                  end_of_grid_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  matched_o;
  logic [POS_W-1:0]      match_row_o;
  logic [POS_W-1:0]      match_col_o;
  logic [TOTAL_W-1:0]    total_count_o;
  logic                  grid_done_o;

  vertical_pattern_match_grid dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .grid_char_i   (grid_char_i),
    .end_of_grid_i (end_of_grid_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .matched_o     (matched_o),
    .match_row_o   (match_row_o),
    .match_col_o   (match_col_o),
    .total_count_o (total_count_o),
    .grid_done_o   (grid_done_o)
  );

  logic [PAT_W-1:0]   cfg_pattern = '0;
  logic [LEN_W-1:0]   cfg_len     = LEN_W'(3);
  logic [WIDTH_W-1:0] cfg_width   = WIDTH_W'(10);
  logic [CHAR_W-1:0]  col_lines [GRID_SIZE][DEPTH];
  int                 pos_row     = 0;
  int                 pos_col     = 0;
  int                 run_total   = 0;

  match_rec_t pending_matches [$];
  grid_step_t directed_steps [$];

  bit src_idle_en   = 1'b0;
  bit sink_idle_en  = 1'b0;
  bit long_hold_req = 1'b0;
  int items_sent    = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_len(logic [LEN_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > MAX_PATTERN) return MAX_PATTERN;
    return int'(raw);
  endfunction

  function automatic int clamp_width(logic [WIDTH_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > GRID_SIZE) return GRID_SIZE;
    return int'(raw);
  endfunction

  function automatic grid_step_t reg_step(logic [1:0] idx, logic [63:0] v);
    reg_step         = '0;
    reg_step.is_cfg  = 1'b1;
    reg_step.reg_idx = idx;
    reg_step.value   = v;
  endfunction

  function automatic grid_step_t char_step(logic [CHAR_W-1:0] c, logic e);
    char_step     = '0;
    char_step.ch  = c;
    char_step.eog = e;
  endfunction

  function automatic grid_step_t known_step(logic [CHAR_W-1:0] c, logic e, logic has,
                                            match_rec_t r);
    known_step           = char_step(c, e);
    known_step.known     = 1'b1;
    known_step.known_has = has;
    known_step.res       = r;
  endfunction

  task automatic match_step(input logic [CHAR_W-1:0] ch, input logic eog,
                            output bit has, output match_rec_t r);
    int len, w, c, d, k, start;
    bit hit;
    len = clamp_len(cfg_len);
    w   = clamp_width(cfg_width);
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1) % GRID_SIZE;
    end
    c     = pos_col;
    hit   = 1'b0;
    start = 0;
    if (pos_row + 1 >= len) begin
      hit = (cfg_pattern[CHAR_W*(len-1) +: CHAR_W] == ch);
      for (k = 0; k + 1 < len; k++) begin
        d = len - 2 - k;
        if (col_lines[c][d] != cfg_pattern[CHAR_W*k +: CHAR_W]) hit = 1'b0;
      end
      if (hit) begin
        start     = pos_row + 1 - len;
        run_total = run_total + len;
        if (run_total > int'(TOTAL_MAX)) run_total = int'(TOTAL_MAX);
      end
    end
    for (d = DEPTH - 1; d > 0; d--) col_lines[c][d] = col_lines[c][d-1];
    col_lines[c][0] = ch;
    pos_col   = c + 1;
    has       = hit || eog;
    r.matched = hit;
    r.row     = hit ? POS_W'(start) : '0;
    r.col     = hit ? POS_W'(c) : '0;
    r.total   = TOTAL_W'(run_total);
    r.done    = eog;
    if (eog) begin
      pos_row   = 0;
      pos_col   = 0;
      run_total = 0;
    end
  endtask

  task automatic feed_char(input logic [CHAR_W-1:0] ch, input logic eog, input logic known,
                           input logic known_has, input match_rec_t known_res);
    bit has;
    match_rec_t r;
    if (src_idle_en && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    grid_char_i   <= ch;
    end_of_grid_i <= eog;
    do @(posedge clk_i); while (in_stall_o);
    match_step(ch, eog, has, r);
    if (known) begin
      has = known_has;
      r   = known_res;
    end
    if (has) pending_matches.push_back(r);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PATTERN: cfg_pattern = value;
      REG_LENGTH:  cfg_len     = value[LEN_W-1:0];
      REG_WIDTH:   cfg_width   = value[WIDTH_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic randomise_config();
    logic [63:0]        noise;
    logic [LEN_W-1:0]   lraw;
    logic [WIDTH_W-1:0] wraw;
    bit                 at_start;
    settle();
    noise    = {$urandom, $urandom};
    at_start = (pos_row == 0) && (pos_col == 0);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       apb_write(REG_PATTERN, '0);
        1:       apb_write(REG_PATTERN, '1);
        default: apb_write(REG_PATTERN, {$urandom, $urandom});
      endcase
    end
    lraw = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 15))
                                       : LEN_W'($urandom_range(1, MAX_PATTERN));
    if ($urandom_range(0, 1) == 0)
      apb_write(REG_LENGTH, ($urandom_range(0, 3) == 0) ? {noise[63:LEN_W], lraw} : 64'(lraw));
    if ($urandom_range(0, 7) == 0)      wraw = WIDTH_W'($urandom_range(0, 31));
    else if ($urandom_range(0, 1) == 0) wraw = WIDTH_W'($urandom_range(1, 4));
    else                                wraw = WIDTH_W'($urandom_range(1, GRID_SIZE));
    // Columns beyond the current width have no history in this grid.
    if ($urandom_range(0, 1) == 0 &&
        (at_start || clamp_width(wraw) <= clamp_width(cfg_width)))
      apb_write(REG_WIDTH, ($urandom_range(0, 3) == 0) ? {noise[63:WIDTH_W], wraw}
                                                      : 64'(wraw));
    if ($urandom_range(0, 15) == 0) apb_write(REG_UNUSED, noise);
    apb_release();
  endtask

  task automatic run_grid_chunk();
    int w, len, nrows, n, cut, row, c, k, mode;
    int off [GRID_SIZE];
    logic [CHAR_W-1:0] ch;
    logic last;
    w     = clamp_width(cfg_width);
    len   = clamp_len(cfg_len);
    mode  = $urandom_range(0, 9);
    nrows = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, len + 3);
    n     = nrows * w;
    cut   = (mode >= 8) ? $urandom_range(1, n) : n;
    for (c = 0; c < GRID_SIZE; c++) off[c] = $urandom_range(0, len - 1);
    for (k = 0; k < cut; k++) begin
      row = k / w;
      c   = k % w;
      if (mode == 7) begin
        ch = CHAR_W'($urandom);
      end else begin
        ch = cfg_pattern[CHAR_W*((row + MAX_PATTERN*len - off[c]) % len) +: CHAR_W];
        case ($urandom_range(0, 9))
          0, 1:    ch = CHAR_W'($urandom);
          2:       ch = cfg_pattern[CHAR_W*$urandom_range(0, len - 1) +: CHAR_W];
          default: ;
        endcase
      end
      if (k == cut - 1) last = (mode != 9);
      else              last = (mode == 7) && ($urandom_range(0, 15) == 0);
      feed_char(ch, last, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic run_saturation();
    logic [CHAR_W-1:0] b;
    int k;
    b = CHAR_W'($urandom);
    settle();
    apb_write(REG_PATTERN, {MAX_PATTERN{b}});
    apb_write(REG_LENGTH, 64'(MAX_PATTERN));
    apb_write(REG_WIDTH, 64'd1);
    apb_release();
    long_hold_req = 1'b1;
    for (k = 0; k < SATURATE_ITEMS; k++)
      feed_char(b, k == SATURATE_ITEMS - 1, 1'b0, 1'b0, '0);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    match_rec_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{matched_o, match_row_o, match_col_o, total_count_o, grid_done_o};
      results_seen++;
      if (pending_matches.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result matched=%0b row=%0d col=%0d total=%0d done=%0b",
                   $time, seen.matched, seen.row, seen.col, seen.total, seen.done);
      end else begin
        want = pending_matches.pop_front();
        if (seen !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"%0t: mismatch, expected matched=%0b row=%0d col=%0d total=%0d done=%0b,",
                      " got matched=%0b row=%0d col=%0d total=%0d done=%0b"}, $time,
                     want.matched, want.row, want.col, want.total, want.done,
                     seen.matched, seen.row, seen.col, seen.total, seen.done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles, %0d results outstanding.",
               quiet_cycles, pending_matches.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    grid_step_t step;
    bit sat_done;
    int i;
    sat_done = 1'b0;
    foreach (col_lines[r, d]) col_lines[r][d] = '0;
    directed_steps = {
      known_step(8'h00, 1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 12'd0, 1'b1}),
      reg_step(REG_WIDTH,   64'd2),
      reg_step(REG_LENGTH,  64'd2),
      reg_step(REG_PATTERN, 64'hA5C3_0F1E_7788_FF00),
      reg_step(REG_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF),
      known_step(8'h00, 1'b0, 1'b0, '0),
      known_step(8'hFF, 1'b0, 1'b0, '0),
      known_step(8'hFF, 1'b0, 1'b1, '{1'b1, 4'd0, 4'd0, 12'd2, 1'b0}),
      known_step(8'hFF, 1'b0, 1'b0, '0),
      known_step(8'h00, 1'b0, 1'b0, '0),
      known_step(8'h00, 1'b0, 1'b0, '0),
      known_step(8'hFF, 1'b0, 1'b1, '{1'b1, 4'd2, 4'd0, 12'd4, 1'b0}),
      known_step(8'hFF, 1'b1, 1'b1, '{1'b1, 4'd2, 4'd1, 12'd6, 1'b1}),
      reg_step(REG_LENGTH,  64'd0),
      reg_step(REG_WIDTH,   64'd0),
      known_step(8'h00, 1'b1, 1'b1, '{1'b1, 4'd0, 4'd0, 12'd1, 1'b1}),
      char_step(8'hFF, 1'b0),
      char_step(8'h00, 1'b0),
      char_step(8'h00, 1'b1),
      reg_step(REG_LENGTH,  64'd15),
      reg_step(REG_WIDTH,   64'd31),
      known_step(8'h5A, 1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 12'd0, 1'b1})
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;

    for (i = 0; i < directed_steps.size(); i++) begin
      step = directed_steps[i];
      if (step.is_cfg) begin
        settle();
        apb_write(step.reg_idx, step.value);
        apb_release();
      end else begin
        feed_char(step.ch, step.eog, step.known, step.known_has, step.res);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_AFTER) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      if (!sat_done && items_sent >= SATURATE_AFTER) begin
        run_saturation();
        sat_done = 1'b1;
      end else begin
        randomise_config();
        run_grid_chunk();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d grid characters and checked %0d results over %0d register writes.",
             items_sent, results_seen, cfg_writes);
    $display("Covered clamped registers, row wrap, total saturation and a long output hold.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures.", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: vertical_pattern_match_grid.f
src/vpm_pkg.sv
src/vpm_ram.sv
src/vpm_cfg.sv
src/vpm_match.sv
src/vertical_pattern_match_grid.sv
tb/tb_vertical_pattern_match_grid.sv
